@@ rtl/core/gem_pkg.sv @@
// gem_pkg: shared types, codes and event maps for the gamepad event merger
// depends on nothing; imported by gamepad_event_merger
package gem_pkg;

   localparam int CONNECTORS_DEF = 2;
   localparam int HATS_DEF       = 4;
   localparam int VEC_W          = 12;
   localparam int THR_W          = 15;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = 15'd8000;

   localparam logic [VEC_W-1:0] BIT_R     = 12'h001;
   localparam logic [VEC_W-1:0] BIT_L     = 12'h002;
   localparam logic [VEC_W-1:0] BIT_D     = 12'h004;
   localparam logic [VEC_W-1:0] BIT_U     = 12'h008;
   localparam logic [VEC_W-1:0] BIT_F1    = 12'h010;
   localparam logic [VEC_W-1:0] BIT_F2    = 12'h020;
   localparam logic [VEC_W-1:0] BIT_A     = 12'h040;
   localparam logic [VEC_W-1:0] BIT_START = 12'h080;
   localparam logic [VEC_W-1:0] BIT_MODE  = 12'h800;
   localparam logic [VEC_W-1:0] DIRS      = 12'h00F;

   localparam logic [1:0] SRC_NONE   = 2'd0;
   localparam logic [1:0] SRC_PAD    = 2'd1;
   localparam logic [1:0] SRC_CURSOR = 2'd2;

   typedef enum logic [2:0] {
      MODE_PAD_BUTTON = 3'd0,
      MODE_PAD_AXIS   = 3'd1,
      MODE_RAW_BUTTON = 3'd2,
      MODE_RAW_AXIS   = 3'd3,
      MODE_HAT        = 3'd4,
      MODE_CURSOR     = 3'd5,
      MODE_SELECT     = 3'd6,
      MODE_RESTORE    = 3'd7
   } mode_type;

   typedef struct packed {
      mode_type           mode;
      logic               connector;
      logic [7:0]         code;
      logic               pressed;
      logic signed [15:0] axis_value;
      logic [3:0]         hat_mask;
      logic [11:0]        restore_vector;
   } req_word_type;

   typedef struct packed {
      logic        out_connector;
      logic [11:0] joy_vector;
   } rsp_word_type;

   function automatic logic [VEC_W-1:0] pad_button_bit(input logic [7:0] code);
      logic [VEC_W-1:0] b;
      b = '0;
      unique case (code)
         8'd0:    b = BIT_F1;
         8'd1:    b = BIT_F2;
         8'd2:    b = BIT_A;
         8'd3:    b = BIT_MODE;
         8'd6:    b = BIT_START;
         8'd11:   b = BIT_U;
         8'd12:   b = BIT_D;
         8'd13:   b = BIT_L;
         8'd14:   b = BIT_R;
         default: b = '0;
      endcase
      return b;
   endfunction

   function automatic logic [VEC_W-1:0] raw_button_bit(input logic [7:0] code);
      logic [VEC_W-1:0] b;
      b = '0;
      unique case (code)
         8'd0:    b = BIT_F1;
         8'd1:    b = BIT_F2;
         8'd2:    b = BIT_A;
         8'd3:    b = BIT_MODE;
         8'd4:    b = BIT_START;
         default: b = '0;
      endcase
      return b;
   endfunction

   function automatic logic [VEC_W-1:0] cursor_bit(input logic [7:0] code);
      logic [VEC_W-1:0] b;
      b = '0;
      unique case (code)
         8'd0:    b = BIT_U;
         8'd1:    b = BIT_D;
         8'd2:    b = BIT_L;
         8'd3:    b = BIT_R;
         8'd4:    b = BIT_F1;
         default: b = '0;
      endcase
      return b;
   endfunction

   // hat mask bit0 up, bit1 right, bit2 down, bit3 left into R/L/D/U positions
   function automatic logic [3:0] hat_dirs(input logic [3:0] hat);
      return {hat[0], hat[2], hat[3], hat[1]};
   endfunction

endpackage

@@ rtl/core/gamepad_event_merger.sv @@
// gamepad_event_merger: merges button, axis, hat, cursor, source and restore
// events into one 12-bit joystick vector per connector; uses gem_pkg
//
// Takes one event word per clock while req_stall is low and reports a
// connector's vector whenever an event changes it (a source change always
// reports a zero vector; a restore never reports). An accepted word is held
// in the input register, where its connector's state is updated and the new
// vector is compared with the last one; a reported vector then goes to the
// result register. The input side stalls only while both the input register
// and the result register are full and rsp_stall is high. csr_wr_data sets
// the axis threshold; deflections beyond plus or minus it assert a direction.
module gamepad_event_merger
   import gem_pkg::*;
#(
   parameter int CONNECTORS = CONNECTORS_DEF,
   parameter int HATS       = HATS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_word_type     req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_word_type     rsp_word,
   input  logic             csr_wr_en,
   input  logic [THR_W-1:0] csr_wr_data
);

   logic                   s1_valid_ff;
   req_word_type           s1_word_ff;
   logic                   rsp_valid_ff;
   rsp_word_type           rsp_word_ff;
   logic [THR_W-1:0]       threshold_ff;
   logic                   out_blocked;
   logic                   s1_go;
   logic [CONNECTORS-1:0]  emit_vec;
   logic [VEC_W-1:0]       conn_vec [CONNECTORS];
   logic [VEC_W-1:0]       out_vec;
   logic signed [16:0]     thr_pos;
   logic signed [16:0]     thr_neg;
   logic signed [16:0]     axis_ext;
   logic                   axis_lt;
   logic                   axis_gt;

   assign out_blocked = rsp_valid_ff && rsp_stall;
   assign s1_go       = s1_valid_ff && !out_blocked;
   assign req_stall   = s1_valid_ff && out_blocked;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_word    = rsp_word_ff;

   assign thr_pos  = $signed({2'b00, threshold_ff});
   assign thr_neg  = -thr_pos;
   assign axis_ext = 17'(s1_word_ff.axis_value);
   assign axis_lt  = axis_ext < thr_neg;
   assign axis_gt  = axis_ext > thr_pos;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         threshold_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_word_ff <= req_word;
      end
   end

   for (genvar c = 0; c < CONNECTORS; c++) begin : g_conn
      logic             hit;
      logic [VEC_W-1:0] held_ff, held_in;
      logic [3:0]       rest_ff, rest_in;
      logic [3:0]       axis_ff, axis_in;
      logic [3:0]       hat_ff [HATS];
      logic [3:0]       hat_in [HATS];
      logic [VEC_W-1:0] last_ff, last_in;
      logic [1:0]       src_ff, src_in;
      logic             emit;
      logic             do_merge;
      logic [VEC_W-1:0] merged;
      logic [VEC_W-1:0] pbit;
      logic [VEC_W-1:0] rbit;
      logic [VEC_W-1:0] cbit;
      logic [3:0]       neg_b;
      logic [3:0]       pos_b;
      logic [3:0]       hat_or;

      assign hit  = s1_go && (c < 2) && (s1_word_ff.connector == 1'(c));
      assign pbit = pad_button_bit(s1_word_ff.code);
      assign rbit = raw_button_bit(s1_word_ff.code);
      assign cbit = cursor_bit(s1_word_ff.code);

      always_comb begin
         held_in  = held_ff;
         rest_in  = rest_ff;
         axis_in  = axis_ff;
         hat_in   = hat_ff;
         last_in  = last_ff;
         src_in   = src_ff;
         emit     = 1'b0;
         do_merge = 1'b0;
         neg_b    = 4'(BIT_L);
         pos_b    = 4'(BIT_R);
         if (hit) begin
            unique case (s1_word_ff.mode)
               MODE_PAD_BUTTON: begin
                  if (src_ff == SRC_PAD && pbit != '0) begin
                     if ((pbit & DIRS) != '0) rest_in = '0;
                     held_in  = s1_word_ff.pressed ? (held_ff | pbit) : (held_ff & ~pbit);
                     do_merge = 1'b1;
                  end
               end
               MODE_RAW_BUTTON: begin
                  if (src_ff == SRC_PAD && rbit != '0) begin
                     held_in  = s1_word_ff.pressed ? (held_ff | rbit) : (held_ff & ~rbit);
                     do_merge = 1'b1;
                  end
               end
               MODE_CURSOR: begin
                  if (src_ff == SRC_CURSOR && cbit != '0) begin
                     if ((cbit & DIRS) != '0) rest_in = '0;
                     held_in  = s1_word_ff.pressed ? (held_ff | cbit) : (held_ff & ~cbit);
                     do_merge = 1'b1;
                  end
               end
               MODE_PAD_AXIS, MODE_RAW_AXIS: begin
                  if (src_ff == SRC_PAD &&
                      ((s1_word_ff.mode == MODE_PAD_AXIS && s1_word_ff.code <= 8'd3) ||
                       (s1_word_ff.mode == MODE_RAW_AXIS && s1_word_ff.code <= 8'd1))) begin
                     if (s1_word_ff.code[0]) begin
                        neg_b = 4'(BIT_U);
                        pos_b = 4'(BIT_D);
                     end
                     axis_in = axis_ff & ~(neg_b | pos_b);
                     if (axis_lt) axis_in = axis_in | neg_b;
                     if (axis_gt) axis_in = axis_in | pos_b;
                     rest_in  = '0;
                     do_merge = 1'b1;
                  end
               end
               MODE_HAT: begin
                  if (src_ff == SRC_PAD && s1_word_ff.code < 8'(HATS)) begin
                     for (int h = 0; h < HATS; h++) begin
                        if (s1_word_ff.code == 8'(h)) hat_in[h] = hat_dirs(s1_word_ff.hat_mask);
                     end
                     rest_in  = '0;
                     do_merge = 1'b1;
                  end
               end
               MODE_SELECT: begin
                  if (s1_word_ff.code <= 8'd3 && s1_word_ff.code[1:0] != src_ff) begin
                     src_in  = s1_word_ff.code[1:0];
                     held_in = '0;
                     rest_in = '0;
                     axis_in = '0;
                     for (int h = 0; h < HATS; h++) hat_in[h] = '0;
                     last_in = '0;
                     emit    = 1'b1;
                  end
               end
               MODE_RESTORE: begin
                  held_in = s1_word_ff.restore_vector & ~DIRS;
                  rest_in = s1_word_ff.restore_vector[3:0];
                  axis_in = '0;
                  for (int h = 0; h < HATS; h++) hat_in[h] = '0;
                  last_in = s1_word_ff.restore_vector;
               end
               default: begin
               end
            endcase
         end
         hat_or = '0;
         for (int h = 0; h < HATS; h++) hat_or = hat_or | hat_in[h];
         merged = held_in | {8'h00, rest_in | axis_in | hat_or};
         if (do_merge && merged != last_ff) begin
            emit    = 1'b1;
            last_in = merged;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            held_ff <= '0;
            rest_ff <= '0;
            axis_ff <= '0;
            last_ff <= '0;
            src_ff  <= SRC_PAD;
            for (int h = 0; h < HATS; h++) hat_ff[h] <= '0;
         end else begin
            held_ff <= held_in;
            rest_ff <= rest_in;
            axis_ff <= axis_in;
            last_ff <= last_in;
            src_ff  <= src_in;
            hat_ff  <= hat_in;
         end
      end

      assign emit_vec[c] = emit;
      assign conn_vec[c] = merged;
   end

   always_comb begin
      out_vec = '0;
      for (int c = 0; c < CONNECTORS; c++) begin
         if (emit_vec[c]) out_vec = out_vec | conn_vec[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!out_blocked) begin
         rsp_valid_ff <= s1_valid_ff && (emit_vec != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (!out_blocked) begin
         rsp_word_ff.out_connector <= s1_word_ff.connector;
         rsp_word_ff.joy_vector    <= out_vec;
      end
   end

   // only the addressed connector may report
   assert property (@(posedge clock) disable iff (reset) $onehot0(emit_vec))
      else $error("more than one connector reports");

   // restore never reports
   assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_word_ff.mode == MODE_RESTORE |-> emit_vec == '0)
      else $error("restore word produced a result");

   // a new result comes only from a word held in the input register
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff) && !$past(out_blocked))
      else $error("result appeared without a word");

endmodule

@@ sim/testbench.sv @@
// testbench for gamepad_event_merger: directed and random event words checked
// against a cycle-free predictor of the per-connector joystick vectors
// depends on gem_pkg and gamepad_event_merger
`timescale 1ns / 100ps

module testbench;
   import gem_pkg::*;

   typedef enum logic [1:0] {
      STEP_WORD,
      STEP_THRESHOLD,
      STEP_DRAIN
   } step_kind_type;

   typedef struct packed {
      step_kind_type    kind;
      req_word_type     word;
      logic [THR_W-1:0] threshold;
   } step_type;

   localparam logic [1:0]  SRC_SPARE = 2'd3;
   localparam int          SETTLE_CYCLES = 4;
   localparam int          PHASES = 5;
   localparam int          PHASE_WORDS = 400;
   localparam logic [71:0] PAD_CODES =
      {8'd14, 8'd13, 8'd12, 8'd11, 8'd6, 8'd3, 8'd2, 8'd1, 8'd0};

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_word_type     req_word = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_word_type     rsp_word;
   logic             csr_wr_en = 1'b0;
   logic [THR_W-1:0] csr_wr_data = '0;

   gamepad_event_merger dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [THR_W-1:0] model_threshold;
   logic [VEC_W-1:0] button_bits [CONNECTORS_DEF];
   logic [3:0]       restore_dirs [CONNECTORS_DEF];
   logic [3:0]       hat_bits [CONNECTORS_DEF][HATS_DEF];
   logic [3:0]       axis_bits [CONNECTORS_DEF];
   logic [VEC_W-1:0] last_vector [CONNECTORS_DEF];
   logic [1:0]       source_sel [CONNECTORS_DEF];

   rsp_word_type vectors_due [$];
   step_type     pending_steps [$];

   logic word_taken = 1'b0;
   int   quiet_cycles = 0;
   int   gap_left = 0;
   int   tx_calm = 0;
   int   stall_left = 0;
   int   rx_calm = 0;
   int   errors = 0;
   int   words_taken = 0;
   int   vectors_seen = 0;
   int   thresholds_written = 0;
   logic [7:0] modes_seen = '0;

   function automatic int draw_pause(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 93) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(10, 30);
   endfunction

   function void clear_connector(input int c);
      button_bits[c] = '0;
      restore_dirs[c] = '0;
      axis_bits[c] = '0;
      last_vector[c] = '0;
      for (int h = 0; h < HATS_DEF; h++) hat_bits[c][h] = '0;
   endfunction

   function void reset_model();
      model_threshold = THRESHOLD_RESET;
      for (int c = 0; c < CONNECTORS_DEF; c++) begin
         clear_connector(c);
         source_sel[c] = SRC_PAD;
      end
   endfunction

   function void report_vector(input int c);
      logic [VEC_W-1:0] v;
      rsp_word_type     e;
      v = button_bits[c] | {8'b0, restore_dirs[c]} | {8'b0, axis_bits[c]};
      for (int h = 0; h < HATS_DEF; h++) v = v | {8'b0, hat_bits[c][h]};
      if (v != last_vector[c]) begin
         last_vector[c] = v;
         e.out_connector = c[0];
         e.joy_vector = v;
         vectors_due.push_back(e);
      end
   endfunction

   function void hold_button(input int c, input logic [VEC_W-1:0] b, input logic pressed);
      if (pressed) button_bits[c] = button_bits[c] | b;
      else button_bits[c] = button_bits[c] & ~b;
      report_vector(c);
   endfunction

   function void latch_axis(input int c, input logic is_x, input logic signed [15:0] value);
      logic [3:0] neg;
      logic [3:0] pos;
      int         sval;
      int         lim;
      neg = is_x ? BIT_L[3:0] : BIT_U[3:0];
      pos = is_x ? BIT_R[3:0] : BIT_D[3:0];
      sval = int'(value);
      lim = int'(model_threshold);
      axis_bits[c] = axis_bits[c] & ~(neg | pos);
      if (sval < -lim) axis_bits[c] = axis_bits[c] | neg;
      if (sval > lim) axis_bits[c] = axis_bits[c] | pos;
      restore_dirs[c] = '0;
      report_vector(c);
   endfunction

   function void merge_event(input req_word_type w);
      int               c;
      logic [VEC_W-1:0] b;
      logic [3:0]       m;
      c = int'(w.connector);
      b = '0;
      case (w.mode)
         MODE_PAD_BUTTON: if (source_sel[c] == SRC_PAD) begin
            case (w.code)
               8'd0:    b = BIT_F1;
               8'd1:    b = BIT_F2;
               8'd2:    b = BIT_A;
               8'd3:    b = BIT_MODE;
               8'd6:    b = BIT_START;
               8'd11:   b = BIT_U;
               8'd12:   b = BIT_D;
               8'd13:   b = BIT_L;
               8'd14:   b = BIT_R;
               default: b = '0;
            endcase
            if ((b & DIRS) != '0) restore_dirs[c] = '0;
            if (b != '0) hold_button(c, b, w.pressed);
         end
         MODE_PAD_AXIS: if (source_sel[c] == SRC_PAD && w.code <= 8'd3) begin
            latch_axis(c, !w.code[0], w.axis_value);
         end
         MODE_RAW_BUTTON: if (source_sel[c] == SRC_PAD) begin
            case (w.code)
               8'd0:    b = BIT_F1;
               8'd1:    b = BIT_F2;
               8'd2:    b = BIT_A;
               8'd3:    b = BIT_MODE;
               8'd4:    b = BIT_START;
               default: b = '0;
            endcase
            if (b != '0) hold_button(c, b, w.pressed);
         end
         MODE_RAW_AXIS: if (source_sel[c] == SRC_PAD && w.code <= 8'd1) begin
            latch_axis(c, w.code == 8'd0, w.axis_value);
         end
         MODE_HAT: if (source_sel[c] == SRC_PAD && w.code < HATS_DEF) begin
            m = '0;
            if (w.hat_mask[0]) m = m | BIT_U[3:0];
            if (w.hat_mask[1]) m = m | BIT_R[3:0];
            if (w.hat_mask[2]) m = m | BIT_D[3:0];
            if (w.hat_mask[3]) m = m | BIT_L[3:0];
            restore_dirs[c] = '0;
            hat_bits[c][w.code] = m;
            report_vector(c);
         end
         MODE_CURSOR: if (source_sel[c] == SRC_CURSOR) begin
            case (w.code)
               8'd0:    b = BIT_U;
               8'd1:    b = BIT_D;
               8'd2:    b = BIT_L;
               8'd3:    b = BIT_R;
               8'd4:    b = BIT_F1;
               default: b = '0;
            endcase
            if ((b & DIRS) != '0) restore_dirs[c] = '0;
            if (b != '0) hold_button(c, b, w.pressed);
         end
         MODE_SELECT: if (w.code <= 8'd3 && w.code[1:0] != source_sel[c]) begin
            source_sel[c] = w.code[1:0];
            clear_connector(c);
            vectors_due.push_back('{out_connector: c[0], joy_vector: '0});
         end
         default: begin
            button_bits[c] = w.restore_vector & ~DIRS;
            restore_dirs[c] = w.restore_vector[3:0];
            for (int h = 0; h < HATS_DEF; h++) hat_bits[c][h] = '0;
            axis_bits[c] = '0;
            last_vector[c] = w.restore_vector;
         end
      endcase
   endfunction

   function automatic req_word_type random_event(input logic [THR_W-1:0] thr);
      req_word_type w;
      logic [63:0]  fill;
      int           r;
      int           k;
      logic         pick;
      fill = {$urandom, $urandom};
      w = req_word_type'(fill[$bits(req_word_type)-1:0]);
      r = $urandom_range(0, 99);
      if (r < 22) w.mode = MODE_PAD_BUTTON;
      else if (r < 36) w.mode = MODE_PAD_AXIS;
      else if (r < 46) w.mode = MODE_RAW_BUTTON;
      else if (r < 56) w.mode = MODE_RAW_AXIS;
      else if (r < 70) w.mode = MODE_HAT;
      else if (r < 86) w.mode = MODE_CURSOR;
      else if (r < 93) w.mode = MODE_SELECT;
      else w.mode = MODE_RESTORE;
      pick = $urandom_range(0, 99) < 88;
      case (w.mode)
         MODE_PAD_BUTTON: if (pick) w.code = PAD_CODES[8 * $urandom_range(0, 8) +: 8];
         MODE_PAD_AXIS:   if (pick) w.code = 8'($urandom_range(0, 3));
         MODE_RAW_BUTTON: if (pick) w.code = 8'($urandom_range(0, 4));
         MODE_RAW_AXIS:   if (pick) w.code = 8'($urandom_range(0, 1));
         MODE_HAT:        if (pick) w.code = 8'($urandom_range(0, HATS_DEF - 1));
         MODE_CURSOR:     if (pick) w.code = 8'($urandom_range(0, 4));
         MODE_SELECT: begin
            r = $urandom_range(0, 99);
            if (r < 70) w.code = (r < 35) ? 8'(SRC_PAD) : 8'(SRC_CURSOR);
            else if (r < 90) w.code = (r < 80) ? 8'(SRC_NONE) : 8'(SRC_SPARE);
         end
         default: ;
      endcase
      // bias deflections toward the threshold and the extremes
      r = $urandom_range(0, 99);
      if (r < 10) w.axis_value = 16'sh8000;
      else if (r < 20) w.axis_value = 16'sh7FFF;
      else if (r < 25) w.axis_value = '0;
      else if (r < 60) begin
         k = int'(thr);
         k = k + $urandom_range(0, 2) - 1;
         if ($urandom_range(0, 1)) k = -k;
         w.axis_value = k[15:0];
      end
      return w;
   endfunction

   function void queue_event(input mode_type m, input logic conn, input logic [7:0] code,
                             input logic pressed, input logic signed [15:0] axis,
                             input logic [3:0] hat, input logic [11:0] rv);
      req_word_type w;
      w.mode = m;
      w.connector = conn;
      w.code = code;
      w.pressed = pressed;
      w.axis_value = axis;
      w.hat_mask = hat;
      w.restore_vector = rv;
      pending_steps.push_back('{kind: STEP_WORD, word: w, threshold: '0});
   endfunction

   // sender
   always @(negedge clock) begin
      logic             v;
      req_word_type     w;
      logic             we;
      logic [THR_W-1:0] wd;
      v = req_valid;
      w = req_word;
      we = 1'b0;
      wd = csr_wr_data;
      if (!reset && !(req_valid && !word_taken)) begin
         v = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_steps.size() > 0) begin
            if (pending_steps[0].kind == STEP_WORD) begin
               v = 1'b1;
               w = pending_steps[0].word;
               void'(pending_steps.pop_front());
               gap_left = draw_pause(tx_calm);
            end else if (quiet_cycles >= SETTLE_CYCLES) begin
               if (pending_steps[0].kind == STEP_THRESHOLD) begin
                  we = 1'b1;
                  wd = pending_steps[0].threshold;
               end
               void'(pending_steps.pop_front());
            end
         end
      end
      req_valid <= v;
      req_word <= w;
      csr_wr_en <= we;
      csr_wr_data <= wd;
   end

   // receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         stall_left = draw_pause(rx_calm);
         rsp_stall <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_word_type due;
      if (reset) begin
         reset_model();
         vectors_due.delete();
         word_taken = 1'b0;
         quiet_cycles = 0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            vectors_seen++;
            if (vectors_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected word, expected none, got connector %0d vector %03h",
                        $time, rsp_word.out_connector, rsp_word.joy_vector);
            end else begin
               due = vectors_due.pop_front();
               if (rsp_word.out_connector !== due.out_connector) begin
                  errors++;
                  $display("%0t: connector mismatch, expected %0d, got %0d",
                           $time, due.out_connector, rsp_word.out_connector);
               end
               if (rsp_word.joy_vector !== due.joy_vector) begin
                  errors++;
                  $display("%0t: vector mismatch on connector %0d, expected %03h, got %03h",
                           $time, due.out_connector, due.joy_vector, rsp_word.joy_vector);
               end
            end
         end
         if (csr_wr_en) begin
            model_threshold = csr_wr_data;
            thresholds_written++;
         end
         word_taken = req_valid && !req_stall;
         if (word_taken) begin
            merge_event(req_word);
            words_taken++;
            modes_seen[req_word.mode] = 1'b1;
         end
         if (req_valid || csr_wr_en || rsp_valid !== 1'b0 || vectors_due.size() != 0)
            quiet_cycles = 0;
         else if (quiet_cycles < 100)
            quiet_cycles++;
      end
   end

   initial begin
      #8_000_000;
      $display("gamepad_event_merger verification failed");
      $finish;
   end

   initial begin
      logic [THR_W-1:0] thr;
      // directed: reserved and repeated source codes, maps, threshold edges, restore
      queue_event(MODE_SELECT, 1'b0, 8'd9, 1'b0, 16'sd0, 4'h0, 12'h000);
      queue_event(MODE_SELECT, 1'b0, 8'(SRC_PAD), 1'b0, 16'sd0, 4'h0, 12'h000);
      queue_event(MODE_PAD_BUTTON, 1'b0, 8'd0, 1'b1, 16'sd0, 4'h0, 12'h000);
      queue_event(MODE_PAD_BUTTON, 1'b0, 8'd14, 1'b1, 16'sd0, 4'h0, 12'h000);
      queue_event(MODE_PAD_BUTTON, 1'b0, 8'd255, 1'b1, 16'sd0, 4'h0, 12'h000);
      queue_event(MODE_PAD_AXIS, 1'b0, 8'd0, 1'b0, 16'sh8000, 4'h0, 12'h000);
      queue_event(MODE_PAD_AXIS, 1'b0, 8'd1, 1'b0, 16'sh7FFF, 4'h0, 12'h000);
      queue_event(MODE_PAD_AXIS, 1'b0, 8'd3, 1'b0, 16'sd8000, 4'h0, 12'h000);
      queue_event(MODE_PAD_AXIS, 1'b0, 8'd5, 1'b0, 16'sh7FFF, 4'h0, 12'h000);
      queue_event(MODE_RAW_BUTTON, 1'b1, 8'd4, 1'b1, 16'sd0, 4'h0, 12'h000);
      queue_event(MODE_RAW_BUTTON, 1'b1, 8'd5, 1'b1, 16'sd0, 4'h0, 12'h000);
      queue_event(MODE_RAW_AXIS, 1'b1, 8'd1, 1'b0, -16'sd8001, 4'h0, 12'h000);
      queue_event(MODE_RAW_AXIS, 1'b1, 8'd2, 1'b0, 16'sh8000, 4'h0, 12'h000);
      queue_event(MODE_HAT, 1'b1, 8'd3, 1'b0, 16'sd0, 4'hF, 12'h000);
      queue_event(MODE_HAT, 1'b1, 8'd4, 1'b0, 16'sd0, 4'hF, 12'h000);
      queue_event(MODE_RESTORE, 1'b1, 8'd0, 1'b0, 16'sd0, 4'h0, 12'hFFF);
      queue_event(MODE_PAD_BUTTON, 1'b1, 8'd11, 1'b0, 16'sd0, 4'h0, 12'h000);
      queue_event(MODE_CURSOR, 1'b0, 8'd0, 1'b1, 16'sd0, 4'h0, 12'h000);
      queue_event(MODE_SELECT, 1'b0, 8'(SRC_CURSOR), 1'b0, 16'sd0, 4'h0, 12'h000);
      queue_event(MODE_CURSOR, 1'b0, 8'd0, 1'b1, 16'sd0, 4'h0, 12'h000);
      queue_event(MODE_CURSOR, 1'b0, 8'd4, 1'b1, 16'sd0, 4'h0, 12'h000);
      queue_event(MODE_CURSOR, 1'b0, 8'd9, 1'b1, 16'sd0, 4'h0, 12'h000);
      queue_event(MODE_PAD_BUTTON, 1'b0, 8'd3, 1'b1, 16'sd0, 4'h0, 12'h000);
      queue_event(MODE_RESTORE, 1'b0, 8'd0, 1'b0, 16'sd0, 4'h0, 12'h00F);
      queue_event(MODE_CURSOR, 1'b0, 8'd2, 1'b0, 16'sd0, 4'h0, 12'h000);
      queue_event(MODE_SELECT, 1'b1, 8'(SRC_NONE), 1'b0, 16'sd0, 4'h0, 12'h000);
      queue_event(MODE_SELECT, 1'b1, 8'(SRC_SPARE), 1'b0, 16'sd0, 4'h0, 12'h000);
      queue_event(MODE_SELECT, 1'b0, 8'(SRC_PAD), 1'b0, 16'sd0, 4'h0, 12'h000);
      queue_event(MODE_SELECT, 1'b1, 8'(SRC_PAD), 1'b0, 16'sd0, 4'h0, 12'h000);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       thr = '0;
            1:       thr = '1;
            3:       thr = THRESHOLD_RESET;
            default: thr = THR_W'($urandom_range(1, 32766));
         endcase
         pending_steps.push_back('{kind: STEP_THRESHOLD, word: '0, threshold: thr});
         for (int i = 0; i < PHASE_WORDS; i++) begin
            if (i == PHASE_WORDS / 2)
               pending_steps.push_back('{kind: STEP_DRAIN, word: '0, threshold: '0});
            pending_steps.push_back('{kind: STEP_WORD, word: random_event(thr), threshold: '0});
         end
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_steps.size() > 0 || req_valid) @(posedge clock);
      while (vectors_due.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("covered %0d event words in %0d of 8 modes, %0d threshold settings",
               words_taken, $countones(modes_seen), thresholds_written);
      $display("compared %0d joystick vector words under random sender gaps and stalls",
               vectors_seen);
      if (errors == 0) begin
         $display("gamepad_event_merger verification clean");
      end else begin
         $display("gamepad_event_merger verification failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/gem_pkg.sv
rtl/core/gamepad_event_merger.sv
sim/testbench.sv
